@@ rtl/pack_entry_header_decoder_assert.svh @@
// assertion macros used by the checker file
`ifndef PACK_ENTRY_HEADER_DECODER_ASSERT_SVH
`define PACK_ENTRY_HEADER_DECODER_ASSERT_SVH

// clocked property, ignored while reset is asserted
`define PEHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define PEHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pehd_pkg.sv @@
// ----------------------------------------------------------------------------
// pehd_pkg
// Types and codes shared by the pack entry header decoder modules.
// ----------------------------------------------------------------------------
package pehd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIZE,
        PH_OFFSET
    } t_phase;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SIZE_LONG   = 3'd1;
    localparam logic [2:0] ST_OFFSET_LONG = 3'd2;
    localparam logic [2:0] ST_BAD_BASE    = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd4;

    localparam logic [2:0] KIND_PLAIN_LO  = 3'd1;
    localparam logic [2:0] KIND_PLAIN_HI  = 3'd4;
    localparam logic [2:0] KIND_OFS_DELTA = 3'd6;
    localparam logic [2:0] KIND_REF_DELTA = 3'd7;

    localparam int unsigned QUEUE_DEPTH = 4;

    // one classified header byte
    typedef struct packed {
        logic        start;
        logic        more;
        logic [6:0]  val7;
        logic [62:0] pos;
    } t_hdr_byte;

    // finished header awaiting delivery
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] length;
        logic [4:0]  hdr_bytes;
        logic [2:0]  status;
        logic        chk_base;
        logic [63:0] off;
        logic [62:0] pos;
    } t_result;

endpackage

@@ rtl/pehd_front.sv @@
// ----------------------------------------------------------------------------
// pehd_front
// Input stage: accepts header bytes and splits them into continuation flag,
// payload bits and start marker.
// ----------------------------------------------------------------------------
module pehd_front import pehd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_entry_start,
    input  logic [62:0] i_entry_position,
    output logic        o_item_valid,
    input  logic        i_item_ready,
    output t_hdr_byte   o_item
);

    logic      r_valid;
    t_hdr_byte r_item;
    t_hdr_byte n_item;

    assign o_ready = !r_valid || i_item_ready;

    always_comb begin
        n_item.start = i_entry_start;
        n_item.more  = i_data_byte[7];
        n_item.val7  = i_data_byte[6:0];
        // position only matters on a start byte
        n_item.pos   = i_entry_start ? i_entry_position : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ rtl/pehd_queue.sv @@
// ----------------------------------------------------------------------------
// pehd_queue
// Small register queue between the front and the decode back end.
// ----------------------------------------------------------------------------
module pehd_queue import pehd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    output logic      o_push_ready,
    input  t_hdr_byte i_push_item,
    output logic      o_pop_valid,
    input  logic      i_pop,
    output t_hdr_byte o_pop_item
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_hdr_byte         r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ rtl/pehd_back.sv @@
// ----------------------------------------------------------------------------
// pehd_back
// Decode back end: size and offset varint state machine, result register and
// base position check.
// ----------------------------------------------------------------------------
module pehd_back import pehd_pkg::*; #(
    parameter int unsigned MAX_SIZE_BYTES   = 10,
    parameter int unsigned MAX_OFFSET_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    output logic        o_item_pop,
    input  t_hdr_byte   i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_object_kind,
    output logic [63:0] o_object_length,
    output logic [4:0]  o_header_bytes,
    output logic        o_has_base,
    output logic [62:0] o_base_position,
    output logic [2:0]  o_status
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_size, n_size;
    logic [2:0]  r_kind, n_kind;
    logic [63:0] r_off, n_off;
    logic [62:0] r_pos, n_pos;
    logic [4:0]  r_total, n_total;

    logic        r_res_valid;
    t_result     r_res;
    t_result     n_res;

    logic        emit;
    logic        size_end;
    logic        can_go;
    logic        pop;
    logic [3:0]  cnt_inc;
    logic [6:0]  shift;
    logic [63:0] add_val;
    logic [63:0] off_step;
    logic        bad_base;

    assign cnt_inc  = r_cnt + 4'd1;
    assign shift    = 7'd4 + 7'd7 * (7'(r_cnt) - 7'd1);
    // size bits landing at or past bit 64 are dropped
    assign add_val  = (shift < 7'd64) ? (64'(i_item.val7) << shift[5:0]) : '0;
    assign off_step = (r_cnt == 4'd0) ? 64'(i_item.val7)
                                      : (((r_off + 64'd1) << 7) | 64'(i_item.val7));

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_size   = r_size;
        n_kind   = r_kind;
        n_off    = r_off;
        n_pos    = r_pos;
        n_total  = r_total;
        emit     = 1'b0;
        size_end = 1'b0;
        n_res    = '0;

        if (i_item.start) begin
            n_pos   = i_item.pos;
            n_kind  = i_item.val7[6:4];
            n_size  = 64'(i_item.val7[3:0]);
            n_off   = '0;
            n_cnt   = 4'd1;
            n_total = 5'd1;
            if (i_item.more) begin
                if (4'd1 >= 4'(MAX_SIZE_BYTES)) begin
                    emit         = 1'b1;
                    n_res.status = ST_SIZE_LONG;
                end else begin
                    n_phase = PH_SIZE;
                end
            end else begin
                size_end = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_SIZE: begin
                    n_size  = r_size | add_val;
                    n_cnt   = cnt_inc;
                    n_total = r_total + 5'd1;
                    if (i_item.more) begin
                        if (cnt_inc >= 4'(MAX_SIZE_BYTES)) begin
                            emit         = 1'b1;
                            n_res.status = ST_SIZE_LONG;
                        end
                    end else begin
                        size_end = 1'b1;
                    end
                end
                PH_OFFSET: begin
                    n_off        = off_step;
                    n_cnt        = cnt_inc;
                    n_total      = r_total + 5'd1;
                    emit         = 1'b1;
                    n_res.length = r_size;
                    if (i_item.more) begin
                        if (cnt_inc >= 4'(MAX_OFFSET_BYTES)) begin
                            n_res.status = ST_OFFSET_LONG;
                        end else begin
                            emit = 1'b0;
                        end
                    end else begin
                        // base check happens on the registered result
                        n_res.chk_base = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (size_end) begin
            case (n_kind) inside
                [KIND_PLAIN_LO:KIND_PLAIN_HI], KIND_REF_DELTA: begin
                    emit         = 1'b1;
                    n_res.length = n_size;
                    n_res.status = ST_OK;
                end
                KIND_OFS_DELTA: begin
                    n_phase = PH_OFFSET;
                    n_cnt   = 4'd0;
                    n_off   = '0;
                end
                default: begin
                    emit         = 1'b1;
                    n_res.length = n_size;
                    n_res.status = ST_BAD_TYPE;
                end
            endcase
        end

        if (emit) begin
            n_phase = PH_IDLE;
        end
        n_res.kind      = n_kind;
        n_res.hdr_bytes = n_total;
        n_res.off       = n_off;
        n_res.pos       = n_pos;
    end

    assign can_go     = !r_res_valid || i_ready;
    assign pop        = i_item_valid && (!emit || can_go);
    assign o_item_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_size      <= '0;
            r_kind      <= '0;
            r_off       <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_size  <= n_size;
                r_kind  <= n_kind;
                r_off   <= n_off;
                r_pos   <= n_pos;
                r_total <= n_total;
            end
            if (pop && emit) begin
                r_res_valid <= 1'b1;
            end else if (i_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_res <= n_res;
        end
    end

    // negative offset must stay below the entry position
    assign bad_base        = (r_res.off >= {1'b0, r_res.pos});
    assign o_valid         = r_res_valid;
    assign o_object_kind   = r_res.kind;
    assign o_object_length = r_res.length;
    assign o_header_bytes  = r_res.hdr_bytes;
    assign o_has_base      = r_res.chk_base && !bad_base;
    assign o_base_position = o_has_base ? (r_res.pos - r_res.off[62:0]) : '0;
    assign o_status        = r_res.chk_base ? (bad_base ? ST_BAD_BASE : ST_OK)
                                            : r_res.status;

endmodule

@@ rtl/pack_entry_header_decoder.sv @@
// A header's last byte passes the input register and queue into the result register.
// Throughput: one header byte per cycle, stalling while a result waits on i_ready.
// A four-entry queue between the input stage and the decoder absorbs output stalls.
// Reset: synchronous, active low; clears the queue, decoder phase and result valid.
// ----------------------------------------------------------------------------
// pack_entry_header_decoder
// Decodes packed object headers: kind, varint size and, for offset deltas,
// the base position.
// ----------------------------------------------------------------------------
module pack_entry_header_decoder import pehd_pkg::*; #(
    parameter int unsigned MAX_SIZE_BYTES   = 10,
    parameter int unsigned MAX_OFFSET_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_entry_start,
    input  logic [62:0] i_entry_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_object_kind,
    output logic [63:0] o_object_length,
    output logic [4:0]  o_header_bytes,
    output logic        o_has_base,
    output logic [62:0] o_base_position,
    output logic [2:0]  o_status
);

    logic      f_valid;
    logic      f_ready;
    t_hdr_byte f_item;
    logic      q_valid;
    logic      q_pop;
    t_hdr_byte q_item;

    pehd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_entry_start    (i_entry_start),
        .i_entry_position (i_entry_position),
        .o_item_valid     (f_valid),
        .i_item_ready     (f_ready),
        .o_item           (f_item)
    );

    pehd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_item   (q_item)
    );

    pehd_back #(
        .MAX_SIZE_BYTES   (MAX_SIZE_BYTES),
        .MAX_OFFSET_BYTES (MAX_OFFSET_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (q_valid),
        .o_item_pop      (q_pop),
        .i_item          (q_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_object_kind   (o_object_kind),
        .o_object_length (o_object_length),
        .o_header_bytes  (o_header_bytes),
        .o_has_base      (o_has_base),
        .o_base_position (o_base_position),
        .o_status        (o_status)
    );

endmodule

@@ rtl/pehd_checker.sv @@
// ----------------------------------------------------------------------------
// pehd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pack_entry_header_decoder_assert.svh"

module pehd_checker import pehd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_object_kind,
    input logic [63:0] o_object_length,
    input logic [4:0]  o_header_bytes,
    input logic        o_has_base,
    input logic [62:0] o_base_position,
    input logic [2:0]  o_status
);

    // a stalled result transaction holds its payload
    `PEHD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_object_length) && $stable(o_status) && $stable(o_base_position)), "result changed while stalled")

    // a base is only reported for a clean offset delta
    `PEHD_ASSERT(a_base_kind, i_clk, i_rst_n, (o_valid && o_has_base) |-> (o_status == ST_OK && o_object_kind == KIND_OFS_DELTA), "base reported on wrong kind or status")

    // no base means a zero base position
    `PEHD_ASSERT(a_base_zero, i_clk, i_rst_n, (o_valid && !o_has_base) |-> (o_base_position == '0), "base position not cleared")

    // overlong size field reports zero length and some header bytes
    `PEHD_ASSERT(a_size_long, i_clk, i_rst_n, (o_valid && o_status == ST_SIZE_LONG) |-> (o_object_length == '0 && o_header_bytes != '0), "overlong size result malformed")

    // nothing is offered straight out of reset
    `PEHD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind pack_entry_header_decoder pehd_checker u_pehd_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pack entry header decoder. Header bytes are
// sent one transaction at a time; an in-bench decoder predicts each result
// and a monitor compares every result transaction with the oldest prediction.
// Directed headers cover every kind, field extremes and the error paths,
// then random headers, most with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import pehd_pkg::*;

    localparam int unsigned SIZE_BYTES_MAX   = 10;
    localparam int unsigned OFFSET_BYTES_MAX = 9;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES      = 20;
    localparam logic [62:0] POS_MAX          = {63{1'b1}};

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] length;
        logic [4:0]  hdr_bytes;
        logic        has_base;
        logic [62:0] base;
        logic [2:0]  status;
    } t_hdr_result;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic [7:0]  i_data_byte      = '0;
    logic        i_entry_start    = 1'b0;
    logic [62:0] i_entry_position = '0;
    logic        i_ready          = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_object_kind;
    logic [63:0] o_object_length;
    logic [4:0]  o_header_bytes;
    logic        o_has_base;
    logic [62:0] o_base_position;
    logic [2:0]  o_status;

    // decoder state mirrored by the bench
    t_phase      dec_phase = PH_IDLE;
    bit [3:0]    dec_fcnt  = '0;
    bit [63:0]   dec_size  = '0;
    bit [2:0]    dec_kind  = '0;
    bit [63:0]   dec_ofs   = '0;
    bit [62:0]   dec_pos   = '0;
    bit [4:0]    dec_total = '0;

    t_hdr_result pending_headers[$];

    bit          src_idle_en = 1'b0;
    bit          snk_idle_en = 1'b0;
    int unsigned ready_hold  = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned live_bytes  = 0;
    int unsigned results_seen = 0;
    int unsigned status_hits[8];

    pack_entry_header_decoder #(
        .MAX_SIZE_BYTES  (SIZE_BYTES_MAX),
        .MAX_OFFSET_BYTES(OFFSET_BYTES_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_entry_start   (i_entry_start),
        .i_entry_position(i_entry_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_object_kind   (o_object_kind),
        .o_object_length (o_object_length),
        .o_header_bytes  (o_header_bytes),
        .o_has_base      (o_has_base),
        .o_base_position (o_base_position),
        .o_status        (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // header prediction
    // ------------------------------------------------------------------------
    function automatic t_hdr_result close_header(input bit [63:0] len, input bit hb,
                                                 input bit [62:0] base, input bit [2:0] st);
        t_hdr_result r;
        r.kind      = dec_kind;
        r.length    = len;
        r.hdr_bytes = dec_total;
        r.has_base  = hb;
        r.base      = hb ? base : '0;
        r.status    = st;
        dec_phase   = PH_IDLE;
        return r;
    endfunction

    function automatic bit size_field_done(output t_hdr_result r);
        r = '0;
        if ((dec_kind >= KIND_PLAIN_LO && dec_kind <= KIND_PLAIN_HI) ||
            dec_kind == KIND_REF_DELTA) begin
            r = close_header(dec_size, 1'b0, '0, ST_OK);
            return 1'b1;
        end
        if (dec_kind == KIND_OFS_DELTA) begin
            dec_phase = PH_OFFSET;
            dec_fcnt  = '0;
            dec_ofs   = '0;
            return 1'b0;
        end
        r = close_header(dec_size, 1'b0, '0, ST_BAD_TYPE);
        return 1'b1;
    endfunction

    function automatic bit decode_header_byte(input bit [7:0] b, input bit start,
                                              input bit [62:0] pos, output t_hdr_result r);
        bit       more;
        bit [6:0] v7;
        int       sh;
        more = b[7];
        v7   = b[6:0];
        r    = '0;
        if (start) begin
            dec_pos   = pos;
            dec_kind  = b[6:4];
            dec_size  = {60'd0, b[3:0]};
            dec_ofs   = '0;
            dec_fcnt  = 4'd1;
            dec_total = 5'd1;
            if (more) begin
                if (dec_fcnt >= SIZE_BYTES_MAX) begin
                    r = close_header('0, 1'b0, '0, ST_SIZE_LONG);
                    return 1'b1;
                end
                dec_phase = PH_SIZE;
                return 1'b0;
            end
            return size_field_done(r);
        end
        if (dec_phase == PH_SIZE) begin
            sh = 4 + 7 * (int'(dec_fcnt) - 1);
            // anything shifted past bit 63 is lost
            if (sh < 64)
                dec_size = dec_size | ({57'd0, v7} << sh);
            dec_fcnt  = dec_fcnt + 4'd1;
            dec_total = dec_total + 5'd1;
            if (more) begin
                if (dec_fcnt >= SIZE_BYTES_MAX) begin
                    r = close_header('0, 1'b0, '0, ST_SIZE_LONG);
                    return 1'b1;
                end
                return 1'b0;
            end
            return size_field_done(r);
        end
        if (dec_phase == PH_OFFSET) begin
            // big-endian, each continuation adds one before the shift
            if (dec_fcnt == 0)
                dec_ofs = {57'd0, v7};
            else
                dec_ofs = ((dec_ofs + 64'd1) << 7) + {57'd0, v7};
            dec_fcnt  = dec_fcnt + 4'd1;
            dec_total = dec_total + 5'd1;
            if (more) begin
                if (dec_fcnt >= OFFSET_BYTES_MAX) begin
                    r = close_header(dec_size, 1'b0, '0, ST_OFFSET_LONG);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (dec_ofs >= {1'b0, dec_pos}) begin
                r = close_header(dec_size, 1'b0, '0, ST_BAD_BASE);
                return 1'b1;
            end
            r = close_header(dec_size, 1'b1, dec_pos - dec_ofs[62:0], ST_OK);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic bit [62:0] rand_position();
        case ($urandom_range(0, 5))
            0:       return 63'($urandom_range(0, 3));
            1:       return POS_MAX;
            2:       return 63'($urandom_range(0, 1 << 20));
            default: return 63'({$urandom, $urandom});
        endcase
    endfunction

    function automatic bit [6:0] rand_val7();
        case ($urandom_range(0, 7))
            0:       return 7'h00;
            1:       return 7'h7f;
            default: return 7'($urandom);
        endcase
    endfunction

    // one input transaction; valid stays high on return so back-to-back
    // sends keep the bus busy
    task automatic send_byte(input bit [7:0] b, input bit start, input bit [62:0] pos);
        t_hdr_result r;
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_entry_start    <= start;
        i_entry_position <= pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        if (start || dec_phase != PH_IDLE)
            live_bytes++;
        if (decode_header_byte(b, start, pos, r))
            pending_headers.push_back(r);
    endtask

    task automatic release_bus();
        i_valid <= 1'b0;
    endtask

    // whole header, optionally cut short after a number of bytes
    task automatic send_header(input bit [2:0] kind, input int n_size, input bit size_over,
                               input int n_ofs, input bit ofs_over, input int cut,
                               input bit [62:0] pos);
        int       sent;
        bit       more;
        bit [6:0] v;
        sent = 0;
        for (int i = 0; i < n_size; i++) begin
            if (cut > 0 && sent >= cut)
                return;
            more = (i < n_size - 1) || size_over;
            v    = rand_val7();
            if (i == 0)
                send_byte({more, kind, v[3:0]}, 1'b1, pos);
            else
                send_byte({more, v}, 1'b0, rand_position());
            sent++;
        end
        if (kind != KIND_OFS_DELTA || size_over)
            return;
        for (int j = 0; j < n_ofs; j++) begin
            if (cut > 0 && sent >= cut)
                return;
            more = (j < n_ofs - 1) || ofs_over;
            send_byte({more, rand_val7()}, 1'b0, rand_position());
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_header_kinds();
        for (int k = 0; k < 8; k++) begin
            if (3'(k) == KIND_OFS_DELTA) begin
                // zero offset from the top position gives the largest base
                send_byte({1'b0, 3'(k), 4'hf}, 1'b1, POS_MAX);
                send_byte(8'h00, 1'b0, '0);
            end else begin
                send_byte({1'b0, 3'(k), (k % 2) ? 4'hf : 4'h0}, 1'b1,
                          (k % 2) ? POS_MAX : 63'd0);
            end
        end
    endtask

    task automatic test_bad_base();
        send_byte({1'b0, KIND_OFS_DELTA, 4'h3}, 1'b1, 63'd0);
        send_byte(8'h00, 1'b0, POS_MAX);
    endtask

    task automatic test_stray_bytes();
        send_byte(8'hff, 1'b0, POS_MAX);
    endtask

    task automatic test_restart_in_header();
        send_byte({1'b1, KIND_PLAIN_LO, 4'hf}, 1'b1, 63'd0);
    endtask

    task automatic test_size_overrun();
        send_byte({1'b1, KIND_REF_DELTA, 4'hf}, 1'b1, POS_MAX);
        repeat (SIZE_BYTES_MAX - 1) send_byte(8'hff, 1'b0, '0);
    endtask

    task automatic test_offset_overrun();
        send_byte({1'b0, KIND_OFS_DELTA, 4'ha}, 1'b1, POS_MAX);
        repeat (OFFSET_BYTES_MAX) send_byte(8'hff, 1'b0, '0);
    endtask

    task automatic test_random_headers(input int unsigned n_bytes, input bit quiet);
        int unsigned target;
        int          pick;
        bit [2:0]    kind;
        int          n_size, n_ofs, cut;
        bit          size_over, ofs_over;
        target = live_bytes + n_bytes;
        while (live_bytes < target) begin
            if (quiet) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end else if ($urandom_range(0, 39) == 0) begin
                src_idle_en = $urandom_range(0, 1);
                snk_idle_en = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_byte(8'($urandom), 1'b0, rand_position());
            end else begin
                kind = ($urandom_range(0, 9) < 3) ? KIND_OFS_DELTA : 3'($urandom_range(0, 7));
                size_over = ($urandom_range(0, 19) == 0);
                case ($urandom_range(0, 9))
                    0:       n_size = $urandom_range(4, SIZE_BYTES_MAX);
                    default: n_size = $urandom_range(1, 3);
                endcase
                if (size_over)
                    n_size = SIZE_BYTES_MAX;
                ofs_over = ($urandom_range(0, 19) == 0);
                case ($urandom_range(0, 9))
                    0:       n_ofs = $urandom_range(4, OFFSET_BYTES_MAX);
                    default: n_ofs = $urandom_range(1, 3);
                endcase
                if (ofs_over)
                    n_ofs = OFFSET_BYTES_MAX;
                // a broken header is abandoned by the next start
                cut = (pick < 14) ? $urandom_range(1, n_size + 1) : 0;
                send_header(kind, n_size, size_over, n_ofs, ofs_over, cut, rand_position());
            end
        end
    endtask

    task automatic test_pause_until_drained();
        release_bus();
        wait (pending_headers.size() == 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // sink side and result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!snk_idle_en) begin
            i_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_ready && $urandom_range(0, 11) == 0) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 17);
        end else if (!i_ready) begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 25);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_hdr_result got;
        t_hdr_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_object_kind, o_object_length, o_header_bytes,
                    o_has_base, o_base_position, o_status};
            results_seen++;
            if (pending_headers.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%t unexpected result: kind %0d len %h hdr %0d base %0d/%h st %0d",
                             $realtime, got.kind, got.length, got.hdr_bytes,
                             got.has_base, got.base, got.status);
            end else begin
                want = pending_headers.pop_front();
                status_hits[want.status]++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%t result mismatch", $realtime);
                        $display("  exp: kind %0d len %h hdr %0d base %0d/%h st %0d",
                                 want.kind, want.length, want.hdr_bytes,
                                 want.has_base, want.base, want.status);
                        $display("  got: kind %0d len %h hdr %0d base %0d/%h st %0d",
                                 got.kind, got.length, got.hdr_bytes,
                                 got.has_base, got.base, got.status);
                    end
                end
            end
        end
    end

    // cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        test_header_kinds();
        test_bad_base();
        test_stray_bytes();
        test_restart_in_header();
        test_size_overrun();
        test_offset_overrun();

        test_random_headers(900, 1'b0);
        test_pause_until_drained();
        test_random_headers(650, 1'b0);
        test_random_headers(300, 1'b1);

        release_bus();
        wait (pending_headers.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count += pending_headers.size();

        $display("covered %0d header bytes (%0d inside headers), %0d results checked",
                 bytes_sent, live_bytes, results_seen);
        $display("by status: ok %0d, size overrun %0d, offset overrun %0d, bad base %0d, bad kind %0d",
                 status_hits[ST_OK], status_hits[ST_SIZE_LONG], status_hits[ST_OFFSET_LONG],
                 status_hits[ST_BAD_BASE], status_hits[ST_BAD_TYPE]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
